[rtl/blf_pkg.sv]
// ----------------------------------------------------------------------------
// blf_pkg
// Shared types, constants and helpers for the learning bridge forwarding block.
// ----------------------------------------------------------------------------
package blf_pkg;

    // Default parameter values
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int MAX_PORTS_DEF     = 8;
    localparam int ADDR_BITS_DEF     = 48;

    // Fixed field widths
    localparam int PORT_W = 4;
    localparam int MASK_W = 8;
    localparam int ACT_W  = 2;

    // Reset value of the ports-in-use register
    localparam logic [PORT_W-1:0] PORTS_IN_USE_RST = 4'd8;

    // Depths of the request and result queues
    localparam int REQ_Q_DEPTH = 2;
    localparam int RES_Q_DEPTH = 2;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_FILTER  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FORWARD = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FLOOD   = 2'd2;

    // One forwarding result
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [PORT_W-1:0] out_port;
        logic [MASK_W-1:0] flood_mask;
        logic              learned;
        logic              table_full;
    } t_result;

    // Mask bit for one port; ports outside 1..MASK_W set nothing
    function automatic logic [MASK_W-1:0] port_bit(input logic [PORT_W-1:0] port);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int p = 1; p <= MASK_W; p++) begin
            if (port == PORT_W'(p)) begin
                m[p-1] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

[rtl/blf_queue.sv]
// ----------------------------------------------------------------------------
// blf_queue
// Small flop-based FIFO with full/empty flags, used between the block's parts.
// ----------------------------------------------------------------------------
module blf_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_cnt,  n_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // Pointer and fill count update
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_wr) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_rd) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

[rtl/blf_front.sv]
// ----------------------------------------------------------------------------
// blf_front
// Accepts frame headers, holds the ports-in-use register, precomputes the
// flood mask and the source-equals-destination flag, and queues the request.
// ----------------------------------------------------------------------------
module blf_front #(
    parameter int MAX_PORTS = 8,
    parameter int ADDR_BITS = 48,
    parameter int REQ_W     = 2 * 48 + 13
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [ADDR_BITS-1:0]      i_src_addr,
    input  logic [ADDR_BITS-1:0]      i_dst_addr,
    input  logic [blf_pkg::PORT_W-1:0] i_in_port,
    input  logic                      i_cfg_we,
    input  logic [blf_pkg::PORT_W-1:0] i_cfg_wdata,
    input  logic                      i_req_pop,
    output logic [REQ_W-1:0]          o_req_data,
    output logic                      o_req_empty
);
    import blf_pkg::*;

    localparam logic [PORT_W:0] MAXP = (PORT_W + 1)'(MAX_PORTS);

    logic [PORT_W-1:0] r_ports_in_use;
    logic [PORT_W:0]   w_nports;
    logic [MASK_W-1:0] w_flood;
    logic              w_same;
    logic [REQ_W-1:0]  w_req;

    // Ports-in-use register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ports_in_use <= PORTS_IN_USE_RST;
        end else if (i_cfg_we) begin
            r_ports_in_use <= i_cfg_wdata;
        end
    end

    // Flood mask: ports 1..nports except the ingress port
    always_comb begin
        w_nports = ({1'b0, r_ports_in_use} > MAXP) ? MAXP : {1'b0, r_ports_in_use};
        w_flood  = '0;
        for (int p = 1; p <= MASK_W; p++) begin
            w_flood[p-1] = ((PORT_W + 1)'(p) <= w_nports) && (PORT_W'(p) != i_in_port);
        end
    end

    assign w_same = (i_src_addr == i_dst_addr);
    assign w_req  = {i_src_addr, i_dst_addr, i_in_port, w_flood, w_same};

    // Request queue toward the table engine
    blf_queue #(
        .WIDTH (REQ_W),
        .DEPTH (REQ_Q_DEPTH)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (w_req),
        .o_full  (full),
        .i_pop   (i_req_pop),
        .o_rdata (o_req_data),
        .o_empty (o_req_empty)
    );

endmodule

[rtl/blf_engine.sv]
// ----------------------------------------------------------------------------
// blf_engine
// Address table and its sequencer: scans the valid entries one per cycle for
// the source and destination, learns the source, and builds the result.
// ----------------------------------------------------------------------------
module blf_engine #(
    parameter int TABLE_ENTRIES = 64,
    parameter int ADDR_BITS     = 48,
    parameter int REQ_W         = 2 * 48 + 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [REQ_W-1:0] i_req_data,
    input  logic             i_req_empty,
    output logic             o_req_pop,
    output logic             o_res_push,
    output blf_pkg::t_result o_res_data,
    input  logic             i_res_full
);
    import blf_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    // Table storage
    logic [ADDR_BITS-1:0] r_mem_addr [TABLE_ENTRIES];
    logic [PORT_W-1:0]    r_mem_port [TABLE_ENTRIES];

    logic [1:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_idx,   n_idx;
    logic                 r_rd_vld, n_rd_vld;
    logic                 r_src_hit, n_src_hit;
    logic                 r_dst_hit, n_dst_hit;
    logic [PORT_W-1:0]    r_dst_port, n_dst_port;
    logic [ADDR_BITS-1:0] r_rd_addr;
    logic [PORT_W-1:0]    r_rd_port;

    logic [ADDR_BITS-1:0] w_src, w_dst;
    logic [PORT_W-1:0]    w_in_port;
    logic [MASK_W-1:0]    w_flood;
    logic                 w_same;
    logic                 w_issue;
    logic                 w_learn;
    logic                 w_full;
    logic                 w_hit;
    logic [PORT_W-1:0]    w_hit_port;
    t_result              w_res;

    assign {w_src, w_dst, w_in_port, w_flood, w_same} = i_req_data;

    assign w_issue = (r_state == S_SCAN) && (r_idx < r_count);

    // Learn/full decision and destination resolution after the scan
    always_comb begin
        w_learn    = !r_src_hit && (r_count != CNT_W'(TABLE_ENTRIES));
        w_full     = !r_src_hit && (r_count == CNT_W'(TABLE_ENTRIES));
        w_hit      = r_dst_hit || (w_same && w_learn);
        w_hit_port = r_dst_hit ? r_dst_port : w_in_port;

        w_res.learned    = w_learn;
        w_res.table_full = w_full;
        if (w_hit && (w_hit_port == w_in_port)) begin
            w_res.action     = ACT_FILTER;
            w_res.out_port   = '0;
            w_res.flood_mask = '0;
        end else if (w_hit) begin
            w_res.action     = ACT_FORWARD;
            w_res.out_port   = w_hit_port;
            w_res.flood_mask = port_bit(w_hit_port);
        end else begin
            w_res.action     = ACT_FLOOD;
            w_res.out_port   = '0;
            w_res.flood_mask = w_flood;
        end
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_rd_vld   = 1'b0;
        n_src_hit  = r_src_hit;
        n_dst_hit  = r_dst_hit;
        n_dst_port = r_dst_port;
        o_req_pop  = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_req_empty) begin
                    n_idx     = '0;
                    n_src_hit = 1'b0;
                    n_dst_hit = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                // compare the entry read last cycle
                if (r_rd_vld) begin
                    if (r_rd_addr == w_src) begin
                        n_src_hit = 1'b1;
                    end
                    if (r_rd_addr == w_dst) begin
                        n_dst_hit  = 1'b1;
                        n_dst_port = r_rd_port;
                    end
                end
                if (w_issue) begin
                    n_idx    = r_idx + 1'b1;
                    n_rd_vld = 1'b1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_req_pop  = 1'b1;
                    if (w_learn) begin
                        n_count = r_count + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res_data = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
        end
    end

    // Scan bookkeeping, no reset needed
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_src_hit  <= n_src_hit;
        r_dst_hit  <= n_dst_hit;
        r_dst_port <= n_dst_port;
    end

    // Table read port
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_addr <= r_mem_addr[r_idx[IDX_W-1:0]];
            r_rd_port <= r_mem_port[r_idx[IDX_W-1:0]];
        end
    end

    // Table write port: lowest free entry is the fill count
    always_ff @(posedge i_clk) begin
        if (o_res_push && w_learn) begin
            r_mem_addr[r_count[IDX_W-1:0]] <= w_src;
            r_mem_port[r_count[IDX_W-1:0]] <= w_in_port;
        end
    end

endmodule

[rtl/learning_bridge_forwarding.sv]
// ----------------------------------------------------------------------------
// learning_bridge_forwarding
// Transparent learning bridge: per-frame source learning and forwarding
// decision against a station address table.
// ----------------------------------------------------------------------------
// The table engine handles one frame header at a time. The table holds 0 to
// TABLE_ENTRIES learned addresses, and the engine reads one entry per cycle,
// comparing it against both the source and the destination, then learns the
// source and posts the result in a final state that waits while the result
// FIFO is full. Entries fill from the bottom and never age, so no clearing
// pass is needed after reset. Headers queue in a two-deep request FIFO ahead
// of the engine and results in a two-deep FIFO behind it, so either side may
// stall until its queue fills without blocking the other. Write ports_in_use
// only while the block is idle.
// ----------------------------------------------------------------------------
module learning_bridge_forwarding #(
    parameter int TABLE_ENTRIES = blf_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_PORTS     = blf_pkg::MAX_PORTS_DEF,
    parameter int ADDR_BITS     = blf_pkg::ADDR_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request side
    input  logic                       push,
    output logic                       full,
    input  logic [ADDR_BITS-1:0]       i_src_addr,
    input  logic [ADDR_BITS-1:0]       i_dst_addr,
    input  logic [blf_pkg::PORT_W-1:0] i_in_port,
    // result side
    output logic                       empty,
    input  logic                       pop,
    output logic [blf_pkg::ACT_W-1:0]  o_action,
    output logic [blf_pkg::PORT_W-1:0] o_out_port,
    output logic [blf_pkg::MASK_W-1:0] o_flood_mask,
    output logic                       o_learned,
    output logic                       o_table_full,
    // configuration
    input  logic                       i_cfg_we,
    input  logic [blf_pkg::PORT_W-1:0] i_cfg_wdata
);
    import blf_pkg::*;

    localparam int REQ_W = 2 * ADDR_BITS + PORT_W + MASK_W + 1;
    localparam int RES_W = $bits(t_result);

    logic [REQ_W-1:0] w_req_data;
    logic             w_req_empty;
    logic             w_req_pop;
    logic             w_res_push;
    t_result          w_res_in;
    logic             w_res_full;
    logic [RES_W-1:0] w_res_raw;
    t_result          w_res_out;

    // Front: accept and classify
    blf_front #(
        .MAX_PORTS (MAX_PORTS),
        .ADDR_BITS (ADDR_BITS),
        .REQ_W     (REQ_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_src_addr  (i_src_addr),
        .i_dst_addr  (i_dst_addr),
        .i_in_port   (i_in_port),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_pop   (w_req_pop),
        .o_req_data  (w_req_data),
        .o_req_empty (w_req_empty)
    );

    // Back: table scan, learning and decision
    blf_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_BITS     (ADDR_BITS),
        .REQ_W         (REQ_W)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (w_req_data),
        .i_req_empty (w_req_empty),
        .o_req_pop   (w_req_pop),
        .o_res_push  (w_res_push),
        .o_res_data  (w_res_in),
        .i_res_full  (w_res_full)
    );

    // Result queue
    blf_queue #(
        .WIDTH (RES_W),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_wdata (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_rdata (w_res_raw),
        .o_empty (empty)
    );

    assign w_res_out    = t_result'(w_res_raw);
    assign o_action     = w_res_out.action;
    assign o_out_port   = w_res_out.out_port;
    assign o_flood_mask = w_res_out.flood_mask;
    assign o_learned    = w_res_out.learned;
    assign o_table_full = w_res_out.table_full;

endmodule

[sim/learning_bridge_forwarding_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// learning_bridge_forwarding_tb
// Self-checking bench for the learning bridge forwarding block. Frame header
// requests come from a pending queue. A clocked driver pushes them with random
// gaps. A clocked monitor pops results with random stalls. Each accepted
// request runs through a local station table model, and every popped result
// is checked field by field against the oldest prediction. The run covers
// directed corner frames first, then phases of random station traffic at
// several ports-in-use settings, and it fills the table past capacity.
// ----------------------------------------------------------------------------
module learning_bridge_forwarding_tb;

    import blf_pkg::*;

    localparam int ADDR_W      = ADDR_BITS_DEF;
    localparam int TABLE_N     = TABLE_ENTRIES_DEF;
    localparam int PORTS_MAX   = MAX_PORTS_DEF;
    localparam int N_STATIONS  = 80;
    localparam int PHASE_ITEMS = 48;
    localparam int N_PHASES    = 8;
    localparam int TAIL_CYCLES = 100;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [PORT_W-1:0] port;
    } t_frame;

    // DUT connections; the driven inputs are known from time zero
    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                push         = 1'b0;
    logic                full;
    logic [ADDR_W-1:0]   i_src_addr   = '0;
    logic [ADDR_W-1:0]   i_dst_addr   = '0;
    logic [PORT_W-1:0]   i_in_port    = '0;
    logic                empty;
    logic                pop          = 1'b0;
    logic [ACT_W-1:0]    o_action;
    logic [PORT_W-1:0]   o_out_port;
    logic [MASK_W-1:0]   o_flood_mask;
    logic                o_learned;
    logic                o_table_full;
    logic                i_cfg_we     = 1'b0;
    logic [PORT_W-1:0]   i_cfg_wdata  = '0;

    // Station table model
    logic [ADDR_W-1:0]   fdb_addr  [TABLE_N];
    logic [PORT_W-1:0]   fdb_port  [TABLE_N];
    bit                  fdb_valid [TABLE_N];
    int                  fdb_count = 0;
    logic [PORT_W-1:0]   ports_cfg = PORTS_IN_USE_RST;

    // Request and decision stores
    t_frame              frame_q[$];
    t_result             decision_q[$];

    // Station pool for well-formed traffic
    logic [ADDR_W-1:0]   station_addr [N_STATIONS];
    logic [PORT_W-1:0]   station_port [N_STATIONS];

    int                  drv_gap = 0;
    int                  mon_gap = 0;
    bit                  no_idle = 1'b0;
    int                  n_errors = 0;
    int                  cycle_cnt = 0;
    int                  n_filter = 0;
    int                  n_forward = 0;
    int                  n_flood = 0;
    int                  n_learned = 0;
    int                  n_full = 0;
    int                  cfg_plan [N_PHASES] = '{2, 15, 0, 1, 9, 5, -1, 8};

    learning_bridge_forwarding u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_src_addr   (i_src_addr),
        .i_dst_addr   (i_dst_addr),
        .i_in_port    (i_in_port),
        .empty        (empty),
        .pop          (pop),
        .o_action     (o_action),
        .o_out_port   (o_out_port),
        .o_flood_mask (o_flood_mask),
        .o_learned    (o_learned),
        .o_table_full (o_table_full),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // Clock and reset
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Mask bit of one port; only ports 1..MASK_W have a bit
    function automatic logic [MASK_W-1:0] mask_of(input logic [PORT_W-1:0] p);
        if (p >= 1 && p <= MASK_W) begin
            return MASK_W'(1) << (p - 1);
        end
        return '0;
    endfunction

    function automatic int fdb_lookup(input logic [ADDR_W-1:0] a);
        int hit;
        hit = -1;
        for (int i = 0; i < TABLE_N; i++) begin
            if (hit < 0 && fdb_valid[i] && fdb_addr[i] == a) begin
                hit = i;
            end
        end
        return hit;
    endfunction

    // Learn the source, then decide filter / forward / flood for the dest
    function automatic t_result fdb_decide(input logic [ADDR_W-1:0] src,
                                           input logic [ADDR_W-1:0] dst,
                                           input logic [PORT_W-1:0] p);
        t_result r;
        int      slot;
        int      hit;
        int      nports;
        r      = '0;
        nports = (ports_cfg > PORTS_MAX) ? PORTS_MAX : int'(ports_cfg);
        if (fdb_lookup(src) < 0) begin
            slot = -1;
            for (int i = 0; i < TABLE_N; i++) begin
                if (slot < 0 && !fdb_valid[i]) begin
                    slot = i;
                end
            end
            if (slot >= 0) begin
                fdb_valid[slot] = 1'b1;
                fdb_addr[slot]  = src;
                fdb_port[slot]  = p;
                fdb_count++;
                r.learned = 1'b1;
            end else begin
                r.table_full = 1'b1;
            end
        end
        hit = fdb_lookup(dst);
        if (hit >= 0 && fdb_port[hit] == p) begin
            r.action = ACT_FILTER;
        end else if (hit >= 0) begin
            r.action     = ACT_FORWARD;
            r.out_port   = fdb_port[hit];
            r.flood_mask = mask_of(fdb_port[hit]);
        end else begin
            r.action = ACT_FLOOD;
            for (int q = 1; q <= nports; q++) begin
                if (q != p) begin
                    r.flood_mask = r.flood_mask | mask_of(PORT_W'(q));
                end
            end
        end
        return r;
    endfunction

    // Driver: push pending requests, hold until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push    <= 1'b0;
            drv_gap = 0;
        end else begin
            if (push && !full) begin
                decision_q.insert(decision_q.size(),
                                  fdb_decide(i_src_addr, i_dst_addr, i_in_port));
            end
            if (push && full) begin
                // request still waiting, keep it on the ports
            end else if (drv_gap > 0) begin
                drv_gap--;
                push <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                drv_gap = $urandom_range(1, 19) - 1;
                push    <= 1'b0;
            end else if (frame_q.size() > 0) begin
                i_src_addr <= frame_q[0].src;
                i_dst_addr <= frame_q[0].dst;
                i_in_port  <= frame_q[0].port;
                void'(frame_q.pop_front());
                push       <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    task automatic check_decision();
        t_result e;
        if (decision_q.size() == 0) begin
            $error("result popped with no request outstanding");
            n_errors++;
        end else begin
            e = decision_q.pop_front();
            if (o_action !== e.action) begin
                $error("action: expected %0d, got %0d", e.action, o_action);
                n_errors++;
            end
            if (o_out_port !== e.out_port) begin
                $error("out_port: expected %0d, got %0d", e.out_port, o_out_port);
                n_errors++;
            end
            if (o_flood_mask !== e.flood_mask) begin
                $error("flood_mask: expected %h, got %h", e.flood_mask, o_flood_mask);
                n_errors++;
            end
            if (o_learned !== e.learned) begin
                $error("learned: expected %0d, got %0d", e.learned, o_learned);
                n_errors++;
            end
            if (o_table_full !== e.table_full) begin
                $error("table_full: expected %0d, got %0d", e.table_full, o_table_full);
                n_errors++;
            end
            case (e.action)
                ACT_FILTER:  n_filter++;
                ACT_FORWARD: n_forward++;
                default:     n_flood++;
            endcase
            n_learned += e.learned;
            n_full    += e.table_full;
        end
    endtask

    // Monitor: pop results with random stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop     <= 1'b0;
            mon_gap = 0;
        end else begin
            if (pop && !empty) begin
                check_decision();
            end
            if (mon_gap > 0) begin
                mon_gap--;
                pop <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                mon_gap = $urandom_range(1, 19) - 1;
                pop     <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [ADDR_W-1:0] a;
        a[31:0]  = $urandom();
        a[47:32] = 16'($urandom_range(0, 65535));
        return a;
    endfunction

    task automatic add_frame(input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] dst,
                             input logic [PORT_W-1:0] p);
        t_frame f;
        f.src  = src;
        f.dst  = dst;
        f.port = p;
        frame_q.insert(frame_q.size(), f);
    endtask

    // Station traffic: mostly known stations on their home port, some noise
    task automatic add_traffic(input int n, input int pool_n);
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [PORT_W-1:0] p;
        int                s;
        for (int k = 0; k < n; k++) begin
            s = $urandom_range(0, pool_n - 1);
            if ($urandom_range(0, 99) < 8) begin
                src = rand_addr();
                p   = PORT_W'($urandom_range(0, 15));
            end else begin
                src = station_addr[s];
                p   = ($urandom_range(0, 99) < 80) ? station_port[s]
                                                  : PORT_W'($urandom_range(0, 15));
            end
            case ($urandom_range(0, 19))
                0, 1:    dst = src;
                2, 3, 4: dst = rand_addr();
                default: dst = station_addr[$urandom_range(0, pool_n - 1)];
            endcase
            add_frame(src, dst, p);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (frame_q.size() != 0 || push || decision_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_ports_in_use(input logic [PORT_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        ports_cfg   = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Stimulus and end of run
    initial begin
        logic [ADDR_W-1:0] ones;
        logic [PORT_W-1:0] cfg_val;
        int                pool_n;
        ones = '1;
        for (int i = 0; i < N_STATIONS; i++) begin
            station_addr[i] = rand_addr();
            station_port[i] = PORT_W'($urandom_range(1, 8));
        end
        wait (i_rst_n === 1'b1);

        // directed frames at the reset port count
        add_frame(48'h0000_0000_00a1, 48'h0000_0000_00b2, 4'd1);   // both unknown: flood
        add_frame(48'h0000_0000_00b2, 48'h0000_0000_00a1, 4'd2);   // forward back
        add_frame(48'h0000_0000_00a1, 48'h0000_0000_00b2, 4'd2);   // known entry not moved
        add_frame(48'h0000_0000_00c3, 48'h0000_0000_00c3, 4'd3);   // src equals dst
        add_frame(ones, 48'h0, 4'd8);
        add_frame(48'h0, ones, 4'd4);
        add_frame(48'h0000_0000_00d4, 48'h0000_0000_00e5, 4'd0);   // ingress port zero
        add_frame(48'h0000_0000_00e5, 48'h0000_0000_00d4, 4'd5);   // forward to port zero
        add_frame(48'h5555_aaaa_0f0f, 48'haaaa_5555_f0f0, 4'd15);  // ingress beyond range
        add_frame(48'haaaa_5555_f0f0, 48'h5555_aaaa_0f0f, 4'd1);   // forward to port 15
        add_frame(48'h8000_0000_0001, 48'h0000_0000_00a1, 4'd9);
        add_frame(48'h0000_0000_00a1, ones, 4'd1);
        add_frame(48'h0000_0000_00b2, 48'h0000_0000_00c3, 4'd2);
        add_frame(ones, ones, 4'd8);
        add_frame(48'h7fff_ffff_fffe, 48'h1234_5678_9abc, 4'd8);
        wait_idle();

        // random phases across port-count settings; last one without idling
        for (int ph = 0; ph < N_PHASES; ph++) begin
            cfg_val = (cfg_plan[ph] < 0) ? PORT_W'($urandom_range(0, 15))
                                         : PORT_W'(cfg_plan[ph]);
            write_ports_in_use(cfg_val);
            if (ph == 0) begin
                add_frame(48'h0000_0000_00b2, ones, 4'd2);                 // stale target
                add_frame(48'h0000_0000_0f01, 48'h0000_0000_0f02, 4'd1);
            end
            no_idle = (ph == N_PHASES - 1);
            pool_n  = (ph < 5) ? 40 : N_STATIONS;
            add_traffic(PHASE_ITEMS, pool_n);
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d filtered, %0d forwarded, %0d flooded frames across %0d settings.",
                 n_filter, n_forward, n_flood, N_PHASES + 1);
        $display("Stations learned: %0d, frames seen with a full table: %0d.",
                 n_learned, n_full);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("Timeout after %0d cycles", cycle_cnt);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
